[rtl/nearest_centroid_labeler_unit_defines.svh]
// Assertion macros for the nearest centroid labeler.
// The macros use the clock clk and the reset arst_n of the module that includes them.
`ifndef NEAREST_CENTROID_LABELER_UNIT_DEFINES_SVH
`define NEAREST_CENTROID_LABELER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define NCLU_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define NCLU_ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define NCLU_ASSERT(name, prop, msg)
`define NCLU_ASSERT_NEVER(name, expr, msg)
`endif

`endif

[rtl/nclu_pkg.sv]
`timescale 1ns / 1ps

package nclu_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_FEATURES = 16;

	localparam int CLUSTER_W  = 4;
	localparam int FEATURE_W  = 4;
	localparam int VALUE_W    = 16;
	localparam int COUNT_W    = 5;
	localparam int DIST_W     = 36;
	localparam int DIFF_W     = VALUE_W + 1;
	localparam int SQ_W       = 2 * VALUE_W;
	localparam int PROD_W     = 2 * DIFF_W;

	localparam int TABLE_DEPTH = MAX_CLUSTERS * MAX_FEATURES;
	localparam int ADDR_W      = CLUSTER_W + FEATURE_W;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Out-of-range counts act as the nearest legal count.
	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] raw);
		logic [COUNT_W-1:0] n;
		n = raw;
		if (raw == '0) begin
			n = COUNT_W'(1);
		end else if (raw > COUNT_W'(MAX_CLUSTERS)) begin
			n = COUNT_W'(MAX_CLUSTERS);
		end
		return n;
	endfunction

endpackage

[rtl/nearest_centroid_labeler_unit.sv]
// Channel     Direction  Handshake             Beat contents
// ----------  ---------  --------------------  -----------------------------------------------
// input       in         in_valid / in_ready   func, cluster_index, feature_index, value, last
// result      out        out_valid / out_ready label, nearest_distance
// config      in         cluster_count_we      cluster_count_wdata
//
// A point feature is processed by the single subtract-square-add unit, visiting one cluster
// per cycle up to n, the active cluster count. A feature marked last then runs a serial
// minimum search over the n accumulated distances.
// Reset clears the accumulators and sets the cluster count to one; the centroid table
// is not cleared. A result that is not yet taken does not block new input beats; only
// the next result waits for it.
`timescale 1ns / 1ps
`include "nearest_centroid_labeler_unit_defines.svh"

module nearest_centroid_labeler_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cluster_count_we,
	input  logic [nclu_pkg::COUNT_W-1:0]        cluster_count_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [nclu_pkg::CLUSTER_W-1:0]      cluster_index,
	input  logic [nclu_pkg::FEATURE_W-1:0]      feature_index,
	input  logic signed [nclu_pkg::VALUE_W-1:0] value,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [nclu_pkg::CLUSTER_W-1:0]      label,
	output logic [nclu_pkg::DIST_W-1:0]         nearest_distance
);

	import nclu_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACC,
		S_CMP,
		S_EMIT
	} state_t;

	state_t                    state_q;
	logic [COUNT_W-1:0]        count_q;
	logic [COUNT_W-1:0]        n_q;
	logic [COUNT_W-1:0]        iss_q;
	logic [COUNT_W-1:0]        cmp_q;
	logic [FEATURE_W-1:0]      fidx_q;
	logic signed [VALUE_W-1:0] x_q;
	logic                      last_q;
	logic [CLUSTER_W-1:0]      best_k_q;
	logic [DIST_W-1:0]         best_d_q;

	logic [VALUE_W-1:0]        mem [TABLE_DEPTH];
	logic [VALUE_W-1:0]        rdata_s1;
	logic                      v_s1;
	logic [CLUSTER_W-1:0]      k_s1;
	logic                      v_s2;
	logic [CLUSTER_W-1:0]      k_s2;
	logic [SQ_W-1:0]           sq_s2;

	logic [DIST_W-1:0]         acc_q [MAX_CLUSTERS];

	logic                      in_fire;
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic [ADDR_W-1:0]         rd_addr;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  prod;
	logic [CLUSTER_W-1:0]      acc_idx;
	logic [DIST_W-1:0]         acc_rd;
	logic [DIST_W:0]           acc_sum;
	logic [DIST_W-1:0]         acc_sat;
	logic                      issue;
	logic                      acc_done;
	logic                      emit_go;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign wr_en    = in_fire && !func;
	assign wr_addr  = {cluster_index, feature_index};
	assign issue    = (state_q == S_ACC) && (iss_q != n_q);
	assign rd_addr  = {iss_q[CLUSTER_W-1:0], fidx_q};
	assign acc_done = (state_q == S_ACC) && (iss_q == n_q) && !v_s1 && !v_s2;
	assign emit_go  = (state_q == S_EMIT) && (!out_valid || out_ready);

	assign diff = {rdata_s1[VALUE_W-1], rdata_s1} - {x_q[VALUE_W-1], x_q};
	assign prod = diff * diff;

	assign acc_idx = (state_q == S_CMP) ? cmp_q[CLUSTER_W-1:0] : k_s2;
	assign acc_rd  = acc_q[acc_idx];
	assign acc_sum = {1'b0, acc_rd} + {{(DIST_W + 1 - SQ_W){1'b0}}, sq_s2};
	assign acc_sat = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		sq_s2 <= prod[SQ_W-1:0];
		k_s1  <= iss_q[CLUSTER_W-1:0];
		k_s2  <= k_s1;
		if (in_fire && func) begin
			x_q    <= value;
			fidx_q <= feature_index;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			count_q          <= COUNT_W'(1);
			n_q              <= COUNT_W'(1);
			iss_q            <= '0;
			cmp_q            <= '0;
			v_s1             <= 1'b0;
			v_s2             <= 1'b0;
			best_k_q         <= '0;
			best_d_q         <= '0;
			out_valid        <= 1'b0;
			label            <= '0;
			nearest_distance <= '0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (cluster_count_we) begin
				count_q <= cluster_count_wdata;
			end
			if (out_valid && out_ready && !emit_go) begin
				out_valid <= 1'b0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) begin
				iss_q <= iss_q + COUNT_W'(1);
			end
			if (v_s2) begin
				acc_q[k_s2] <= acc_sat;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && func) begin
						n_q     <= clamp_count(count_q);
						iss_q   <= '0;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (acc_done) begin
						if (last_q) begin
							best_k_q <= '0;
							best_d_q <= acc_q[0];
							cmp_q    <= COUNT_W'(1);
							state_q  <= S_CMP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_CMP: begin
					if (cmp_q == n_q) begin
						state_q <= S_EMIT;
					end else begin
						if (acc_rd < best_d_q) begin
							best_d_q <= acc_rd;
							best_k_q <= cmp_q[CLUSTER_W-1:0];
						end
						cmp_q <= cmp_q + COUNT_W'(1);
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid        <= 1'b1;
						label            <= best_k_q;
						nearest_distance <= best_d_q;
						for (int i = 0; i < MAX_CLUSTERS; i++) begin
							acc_q[i] <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`NCLU_ASSERT(a_pipe_in_acc, v_s2 |-> (state_q == S_ACC), "accumulate beat outside the accumulate phase")
	`NCLU_ASSERT(a_count_legal, (state_q != S_IDLE) |-> (n_q != '0 && n_q <= COUNT_W'(MAX_CLUSTERS)), "active cluster count out of range")
	`NCLU_ASSERT(a_issue_bound, (state_q == S_ACC) |-> (iss_q <= n_q), "issue counter ran past the cluster count")
	`NCLU_ASSERT(a_result_from_emit, $rose(out_valid) |-> ($past(state_q) == S_EMIT), "result raised outside the emit step")
	`NCLU_ASSERT(a_clear_on_emit, emit_go |=> (acc_q[0] == '0 && out_valid), "accumulators not cleared with the result")

endmodule
